>>> rtl/xcsd_pkg.sv
// Package for the XBin cell stream decoder.
// Holds shared constants, codes and the structs passed between modules.
// No dependencies.
package xcsd_pkg;

   localparam int MAX_COLUMNS = 4096;
   localparam int COL_LIMIT   = (MAX_COLUMNS < 4096) ? MAX_COLUMNS : 4096;
   localparam int COL_W       = 12;
   localparam int WIDTH_W     = 13;
   localparam int ROW_W       = 16;
   localparam int COUNT_W     = 7;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int RSP_DATA_W  = 48;

   localparam logic [WIDTH_W-1:0] COL_LIMIT_W = WIDTH_W'(COL_LIMIT);

   localparam logic [CSR_ADDR_W-1:0] CSR_COLUMNS    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROWS       = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_COMPRESSED = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_FONT_512   = 2'd3;

   localparam logic [1:0] PH_HEAD = 2'd0;
   localparam logic [1:0] PH_CHAR = 2'd1;
   localparam logic [1:0] PH_ATTR = 2'd2;

   localparam logic [1:0] RUN_LITERAL = 2'd0;
   localparam logic [1:0] RUN_CHAR    = 2'd1;
   localparam logic [1:0] RUN_ATTR    = 2'd2;
   localparam logic [1:0] RUN_BOTH    = 2'd3;

   localparam logic RSP_CELL  = 1'b0;
   localparam logic RSP_TRUNC = 1'b1;

   typedef struct packed {
      logic [ROW_W-1:0]   rows;
      logic               compressed;
      logic               font_512;
      logic [WIDTH_W-1:0] width;
   } cfg_type;

   typedef struct packed {
      logic absorb;
      logic step;
      logic err_load;
      logic clear;
   } ctrl_cmd_type;

   typedef struct packed {
      logic work_cell;
      logic work_err;
      logic fin_now;
      logic slot_free;
      logic more_cells;
      logic err_after;
      logic eod_held;
   } dp_status_type;

endpackage

>>> rtl/xcsd_csr.sv
// Configuration registers of the XBin cell stream decoder.
// Derives the effective row width in cells. Uses xcsd_pkg.
module xcsd_csr
   import xcsd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   logic [WIDTH_W-1:0] columns_ff;
   logic [ROW_W-1:0]   rows_ff;
   logic               compressed_ff;
   logic               font_512_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff    <= WIDTH_W'(80);
         rows_ff       <= ROW_W'(25);
         compressed_ff <= 1'b0;
         font_512_ff   <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_addr)
            CSR_COLUMNS:    columns_ff    <= csr_wdata[WIDTH_W-1:0];
            CSR_ROWS:       rows_ff       <= csr_wdata[ROW_W-1:0];
            CSR_COMPRESSED: compressed_ff <= csr_wdata[0];
            CSR_FONT_512:   font_512_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.rows       = rows_ff;
      cfg.compressed = compressed_ff;
      cfg.font_512   = font_512_ff;
      priority if (columns_ff == '0) begin
         cfg.width = WIDTH_W'(1);
      end else if (columns_ff > COL_LIMIT_W) begin
         cfg.width = COL_LIMIT_W;
      end else begin
         cfg.width = columns_ff;
      end
   end

endmodule

>>> rtl/xcsd_ctrl.sv
// Controller of the XBin cell stream decoder.
// Sequences byte intake, cell emission and the truncation result. Uses xcsd_pkg.
module xcsd_ctrl
   import xcsd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type st,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_CELL  = 3'b010,
      S_ERROR = 3'b100
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.absorb = 1'b1;
               priority if (st.work_cell) begin
                  state_in = S_CELL;
               end else if (st.work_err) begin
                  state_in = S_ERROR;
               end else begin
                  cmd.clear = st.fin_now;
               end
            end
         end
         S_CELL: begin
            if (st.slot_free) begin
               cmd.step = 1'b1;
               priority if (st.more_cells) begin
                  state_in = S_CELL;
               end else if (st.err_after) begin
                  state_in = S_ERROR;
               end else begin
                  cmd.clear = st.eod_held;
                  state_in  = S_IDLE;
               end
            end
         end
         S_ERROR: begin
            if (st.slot_free) begin
               cmd.err_load = 1'b1;
               cmd.clear    = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/xcsd_dpath.sv
// Datapath of the XBin cell stream decoder.
// Run state, cell position, held bytes and the result register. Uses xcsd_pkg.
module xcsd_dpath
   import xcsd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tlast,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         st,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   logic [1:0]         phase_ff, phase_in;
   logic [1:0]         kind_ff, kind_in;
   logic [COUNT_W-1:0] left_ff, left_in;
   logic [7:0]         char_ff, char_in;
   logic [7:0]         attr_ff, attr_in;
   logic               cv_ff, cv_in;
   logic               av_ff, av_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic               stop_ff, stop_in;
   logic               eod_ff, eod_in;

   logic                  out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic                  out_user_ff, out_user_in;
   logic                  out_last_ff, out_last_in;

   // intake decode
   logic               ab_hdr;
   logic               ab_cv, ab_av, ab_both;
   logic               ab_cv_post, ab_av_post;
   logic [1:0]         ab_phase;
   logic               ab_cell, ab_err;

   // cell step
   logic               sp_drop;
   logic [WIDTH_W-1:0] sp_col_inc;
   logic               sp_wrap;
   logic [COL_W-1:0]   sp_col;
   logic [ROW_W-1:0]   sp_row;
   logic               sp_stop;
   logic [COUNT_W-1:0] sp_left;
   logic [1:0]         sp_phase;

   function automatic logic [1:0] next_need(input logic [1:0] kind, input logic cv,
                                           input logic av);
      logic [1:0] ph;
      if (kind == RUN_ATTR) begin
         ph = av ? PH_CHAR : PH_ATTR;
      end else begin
         ph = cv ? PH_ATTR : PH_CHAR;
      end
      return ph;
   endfunction

   always_comb begin
      ab_hdr     = (phase_ff == PH_HEAD) || (phase_ff > PH_ATTR) || (left_ff == '0);
      ab_cv      = (phase_ff == PH_CHAR) ? 1'b1 : cv_ff;
      ab_av      = (phase_ff == PH_CHAR) ? av_ff : 1'b1;
      ab_both    = ab_cv && ab_av;
      ab_cv_post = ab_cv;
      ab_av_post = ab_av;
      if (ab_both && (kind_ff != RUN_BOTH)) begin
         ab_cv_post = (kind_ff == RUN_CHAR) ? ab_cv : 1'b0;
         ab_av_post = (kind_ff == RUN_ATTR) ? ab_av : 1'b0;
      end
      ab_phase = next_need(kind_ff, ab_cv_post, ab_av_post);
      ab_cell  = 1'b0;
      ab_err   = 1'b0;
      if (!stop_ff) begin
         if (cfg.compressed) begin
            if (!ab_hdr) begin
               ab_cell = ab_both;
               ab_err  = req_tlast && !ab_both;
            end
         end else begin
            ab_cell = (phase_ff == PH_ATTR);
         end
      end
   end

   always_comb begin
      sp_drop    = (row_ff >= cfg.rows);
      sp_col_inc = {1'b0, col_ff} + WIDTH_W'(1);
      sp_wrap    = (sp_col_inc >= cfg.width);
      sp_col     = col_ff;
      sp_row     = row_ff;
      if (!sp_drop) begin
         sp_col = sp_wrap ? '0 : sp_col_inc[COL_W-1:0];
         sp_row = sp_wrap ? row_ff + ROW_W'(1) : row_ff;
      end
      sp_stop  = sp_drop || (sp_row >= cfg.rows);
      sp_left  = cfg.compressed ? left_ff - COUNT_W'(1) : left_ff;
      sp_phase = (cfg.compressed && (sp_left == '0)) ? PH_HEAD : phase_ff;
   end

   always_comb begin
      st.work_cell  = ab_cell;
      st.work_err   = ab_err;
      st.fin_now    = req_tlast && !ab_cell && !ab_err;
      st.slot_free  = !out_valid_ff || rsp_tready;
      st.more_cells = cfg.compressed && (kind_ff == RUN_BOTH) && (sp_left != '0) && !sp_stop;
      st.err_after  = eod_ff && cfg.compressed && !sp_stop && (sp_phase != PH_HEAD)
                      && (sp_left != '0);
      st.eod_held   = eod_ff;
   end

   always_comb begin
      phase_in = phase_ff;
      kind_in  = kind_ff;
      left_in  = left_ff;
      char_in  = char_ff;
      attr_in  = attr_ff;
      cv_in    = cv_ff;
      av_in    = av_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      stop_in  = stop_ff;
      eod_in   = eod_ff;
      priority if (cmd.clear) begin
         phase_in = PH_HEAD;
         kind_in  = RUN_LITERAL;
         left_in  = '0;
         char_in  = '0;
         attr_in  = '0;
         cv_in    = 1'b0;
         av_in    = 1'b0;
         col_in   = '0;
         row_in   = '0;
         stop_in  = 1'b0;
         eod_in   = 1'b0;
      end else if (cmd.absorb) begin
         eod_in = req_tlast;
         if (!stop_ff) begin
            if (cfg.compressed) begin
               if (ab_hdr) begin
                  if (!req_tlast) begin
                     kind_in  = req_tdata[7:6];
                     left_in  = {1'b0, req_tdata[5:0]} + COUNT_W'(1);
                     cv_in    = 1'b0;
                     av_in    = 1'b0;
                     phase_in = (req_tdata[7:6] == RUN_ATTR) ? PH_ATTR : PH_CHAR;
                  end else begin
                     phase_in = PH_HEAD;
                  end
               end else begin
                  if (phase_ff == PH_CHAR) begin
                     char_in = req_tdata;
                  end else begin
                     attr_in = req_tdata;
                  end
                  cv_in    = ab_cv_post;
                  av_in    = ab_av_post;
                  phase_in = ab_phase;
               end
            end else begin
               if (phase_ff != PH_ATTR) begin
                  char_in  = req_tdata;
                  cv_in    = 1'b1;
                  phase_in = PH_ATTR;
               end else begin
                  attr_in  = req_tdata;
                  cv_in    = 1'b0;
                  av_in    = 1'b0;
                  phase_in = PH_CHAR;
               end
            end
         end
      end else if (cmd.step) begin
         col_in   = sp_col;
         row_in   = sp_row;
         stop_in  = sp_stop;
         left_in  = sp_left;
         phase_in = sp_phase;
      end else begin
         eod_in = eod_ff;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_user_in  = out_user_ff;
      out_last_in  = out_last_ff;
      priority if (cmd.step && !sp_drop) begin
         out_valid_in = 1'b1;
         out_user_in  = RSP_CELL;
         out_last_in  = !st.more_cells && !st.err_after;
         out_data_in  = {3'b000, cfg.font_512 && attr_ff[3], attr_ff[7:4], attr_ff[3:0],
                         char_ff, row_ff, col_ff};
      end else if (cmd.err_load) begin
         out_valid_in = 1'b1;
         out_user_in  = RSP_TRUNC;
         out_last_in  = 1'b1;
         out_data_in  = {20'd0, row_ff, col_ff};
      end else begin
         out_valid_in = out_valid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEAD;
         kind_ff      <= RUN_LITERAL;
         left_ff      <= '0;
         char_ff      <= '0;
         attr_ff      <= '0;
         cv_ff        <= 1'b0;
         av_ff        <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         stop_ff      <= 1'b0;
         eod_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         kind_ff      <= kind_in;
         left_ff      <= left_in;
         char_ff      <= char_in;
         attr_ff      <= attr_in;
         cv_ff        <= cv_in;
         av_ff        <= av_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         stop_ff      <= stop_in;
         eod_ff       <= eod_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      out_user_ff <= out_user_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

>>> rtl/xbin_cell_stream_decoder_top.sv
// XBin cell stream decoder, top level: configuration registers, controller and datapath.
// Uses xcsd_pkg, xcsd_csr, xcsd_ctrl and xcsd_dpath.
//
// Takes the bytes of the cell data section one transfer at a time and puts out one
// transfer per decoded character cell, plus one truncation error transfer (tuser set)
// when the stream ends inside a compressed run. A byte that completes cells holds the
// input while its cells are put out or dropped (up to 64 for a run that repeats both
// character and attribute), and then while any truncation error is loaded. The emit
// sequencer moves one result per cycle through the single output register; a stalled
// output holds the sequencer and the input waits meanwhile. The last transfer caused
// by an input byte carries tlast. Cells at or past the configured row count are
// dropped and later bytes are ignored until end of data.
module xbin_cell_stream_decoder_top
   import xcsd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] data_byte
   input  logic                  req_tlast,   // end_of_data
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [11:0] cell_column, [27:12] cell_row, [35:28] char_code, [39:36] fore_color,
   // [43:40] back_color, [44] high_font, [47:45] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,   // status
   output logic                  rsp_tlast,   // last_of_run
   input  logic                  csr_write_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type       cfg;
   ctrl_cmd_type  cmd;
   dp_status_type st;

   xcsd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   xcsd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   xcsd_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .cmd        (cmd),
      .st         (st),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> tb/tb_top.sv
// Testbench for the XBin cell stream decoder: byte stream in, one transfer per character cell out.
// Predicts cells in place, checks every result field and randomizes idles on both sides.
// Depends on xcsd_pkg and xbin_cell_stream_decoder_top.
`timescale 1ns / 100ps

module tb_top;
   import xcsd_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int RANDOM_BYTES   = 330;

   typedef struct packed {
      logic [7:0] data;
      logic       eod;
   } stream_byte_type;

   typedef struct packed {
      logic        status;
      logic [11:0] column;
      logic [15:0] row;
      logic [7:0]  char_code;
      logic [3:0]  fore;
      logic [3:0]  back;
      logic        high_font;
      logic        last;
   } cell_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = 8'h00;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_write_en = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   xbin_cell_stream_decoder_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast),
      .csr_write_en (csr_write_en),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   stream_byte_type pending_bytes[$];
   cell_type        expected_cells[$];
   cell_type        step_cells[$];
   int              mismatches = 0;
   int              send_gap = 0;
   int              stall_left = 0;
   int              idle_cycles = 0;
   int              random_bytes = 0;
   bit              steady_run = 1'b0;

   // decoder image
   int unsigned cfg_columns, cfg_rows;
   bit          cfg_compressed, cfg_font512;
   logic [1:0]  phase_q, kind_q;
   int unsigned cells_left, col_q, row_q;
   logic [7:0]  char_q, attr_q;
   bit          char_ok, attr_ok, stopped_q;

   function automatic int next_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_run || r < 60)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void clear_stream();
      phase_q = PH_HEAD;
      kind_q = RUN_LITERAL;
      cells_left = 0;
      char_q = 8'h00;
      attr_q = 8'h00;
      char_ok = 1'b0;
      attr_ok = 1'b0;
      col_q = 0;
      row_q = 0;
      stopped_q = 1'b0;
   endfunction

   function automatic int unsigned row_width();
      int unsigned w;
      w = cfg_columns;
      if (w < 1)
         w = 1;
      if (w > MAX_COLUMNS)
         w = MAX_COLUMNS;
      if (w > 4096)
         w = 4096;
      return w;
   endfunction

   function automatic logic [1:0] next_need();
      if (kind_q == RUN_ATTR)
         return attr_ok ? PH_CHAR : PH_ATTR;
      return char_ok ? PH_ATTR : PH_CHAR;
   endfunction

   function automatic void push_cell(logic st, logic [7:0] ch, logic [7:0] at, logic hf);
      cell_type r;
      r.status = st;
      r.column = 12'(col_q);
      r.row = 16'(row_q);
      r.char_code = ch;
      r.fore = at[3:0];
      r.back = at[7:4];
      r.high_font = hf;
      r.last = 1'b0;
      step_cells.push_back(r);
   endfunction

   function automatic void emit_cell();
      if (stopped_q || row_q >= cfg_rows) begin
         stopped_q = 1'b1;
         return;
      end
      push_cell(RSP_CELL, char_q, attr_q, cfg_font512 && attr_q[3]);
      if (col_q + 1 >= row_width()) begin
         col_q = 0;
         row_q++;
      end else begin
         col_q++;
      end
      if (row_q >= cfg_rows)
         stopped_q = 1'b1;
   endfunction

   function automatic void decode_byte(logic [7:0] b, logic eod);
      cell_type r;
      step_cells.delete();
      if (!stopped_q) begin
         if (cfg_compressed) begin
            if (phase_q == PH_HEAD || phase_q > PH_ATTR || cells_left == 0) begin
               if (!eod) begin
                  kind_q = b[7:6];
                  cells_left = b[5:0] + 1;
                  char_ok = 1'b0;
                  attr_ok = 1'b0;
                  phase_q = next_need();
               end else begin
                  phase_q = PH_HEAD;
               end
            end else begin
               if (phase_q == PH_CHAR) begin
                  char_q = b;
                  char_ok = 1'b1;
               end else begin
                  attr_q = b;
                  attr_ok = 1'b1;
               end
               if (char_ok && attr_ok) begin
                  if (kind_q == RUN_BOTH) begin
                     while (cells_left > 0 && !stopped_q) begin
                        emit_cell();
                        cells_left--;
                     end
                  end else begin
                     emit_cell();
                     cells_left--;
                     if (kind_q != RUN_CHAR)
                        char_ok = 1'b0;
                     if (kind_q != RUN_ATTR)
                        attr_ok = 1'b0;
                  end
               end
               phase_q = (cells_left != 0) ? next_need() : PH_HEAD;
            end
            if (eod && !stopped_q && phase_q != PH_HEAD && cells_left != 0)
               push_cell(RSP_TRUNC, 8'h00, 8'h00, 1'b0);
         end else begin
            if (phase_q != PH_ATTR) begin
               char_q = b;
               char_ok = 1'b1;
               phase_q = PH_ATTR;
            end else begin
               attr_q = b;
               attr_ok = 1'b1;
               emit_cell();
               char_ok = 1'b0;
               attr_ok = 1'b0;
               phase_q = PH_CHAR;
            end
         end
      end
      if (eod)
         clear_stream();
      if (step_cells.size() != 0) begin
         r = step_cells.pop_back();
         r.last = 1'b1;
         step_cells.push_back(r);
      end
      while (step_cells.size() != 0)
         expected_cells.push_back(step_cells.pop_front());
   endfunction

   function automatic void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s expected %0d got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // request side: present queued bytes, predict on each transfer
   always @(posedge clock) begin
      stream_byte_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= 8'h00;
         req_tlast <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready)
            decode_byte(req_tdata, req_tlast);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
               nxt = pending_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= nxt.data;
               req_tlast <= nxt.eod;
               send_gap = next_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result side: check each transfer against the oldest expected cell
   always @(posedge clock) begin
      cell_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_cells.size() == 0) begin
               $error("result transfer with no expected cell");
               mismatches++;
            end else begin
               want = expected_cells.pop_front();
               compare_field("status", want.status, rsp_tuser);
               compare_field("cell_column", want.column, rsp_tdata[11:0]);
               compare_field("cell_row", want.row, rsp_tdata[27:12]);
               compare_field("char_code", want.char_code, rsp_tdata[35:28]);
               compare_field("fore_color", want.fore, rsp_tdata[39:36]);
               compare_field("back_color", want.back, rsp_tdata[43:40]);
               compare_field("high_font", want.high_font, rsp_tdata[44]);
               compare_field("last_of_run", want.last, rsp_tlast);
            end
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = next_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   task automatic add_byte(input logic [7:0] d, input logic eod);
      pending_bytes.push_back('{data: d, eod: eod});
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input int unsigned value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      case (idx)
         CSR_COLUMNS:    cfg_columns = value & 32'h1FFF;
         CSR_ROWS:       cfg_rows = value & 32'hFFFF;
         CSR_COMPRESSED: cfg_compressed = value[0];
         CSR_FONT_512:   cfg_font512 = value[0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic set_config(input int unsigned cols, input int unsigned nrows,
                             input bit comp, input bit font);
      write_reg(CSR_COLUMNS, cols);
      write_reg(CSR_ROWS, nrows);
      write_reg(CSR_COMPRESSED, comp);
      write_reg(CSR_FONT_512, font);
   endtask

   // hold until every byte is taken and every cell has arrived, then let the block settle
   task automatic wait_idle();
      @(negedge clock);
      while (pending_bytes.size() != 0 || req_tvalid || expected_cells.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one stream of runs (or char/attr pairs) with a random ending
   task automatic add_stream(input bit comp, input int n_runs);
      logic [7:0] s[$];
      logic [1:0] kind;
      int         count, r, ending, cut;
      for (int i = 0; i < n_runs; i++) begin
         if (!comp) begin
            s.push_back(8'($urandom));
            s.push_back(8'($urandom));
            continue;
         end
         kind = 2'($urandom_range(0, 3));
         r = $urandom_range(0, 99);
         count = (r < 70) ? $urandom_range(1, 4) :
                 (r < 95) ? $urandom_range(5, 16) : $urandom_range(17, 64);
         if ($urandom_range(0, 19) == 0)
            s.push_back(8'($urandom));
         s.push_back({kind, 6'(count - 1)});
         case (kind)
            RUN_LITERAL: repeat (count) begin
               s.push_back(8'($urandom));
               s.push_back(8'($urandom));
            end
            RUN_CHAR, RUN_ATTR: begin
               s.push_back(8'($urandom));
               repeat (count) s.push_back(8'($urandom));
            end
            default: begin
               s.push_back(8'($urandom));
               s.push_back(8'($urandom));
            end
         endcase
      end
      ending = $urandom_range(0, 9);
      if (ending inside {6, 7} && s.size() > 3) begin
         cut = comp ? $urandom_range(1, 3) : 1;
         repeat (cut) void'(s.pop_back());
      end else if (ending == 8) begin
         s.push_back(8'($urandom));
      end
      foreach (s[i])
         add_byte(s[i], (i == s.size() - 1) && ending != 9);
      random_bytes += s.size();
   endtask

   initial begin
      int p;
      int r;
      int unsigned cols, nrows;
      cfg_columns = 80;
      cfg_rows = 25;
      cfg_compressed = 1'b0;
      cfg_font512 = 1'b0;
      clear_stream();

      // reset values: plain pairs, extreme bytes, odd trailing byte
      add_byte(8'h00, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(8'h7E, 1'b1);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait_idle();

      // every run type, truncation, trailing header, image full
      set_config(4, 3, 1'b1, 1'b1);
      add_byte(8'h01, 1'b0);
      add_byte(8'h41, 1'b0);
      add_byte(8'h08, 1'b0);
      add_byte(8'hB0, 1'b0);
      add_byte(8'h07, 1'b0);
      add_byte(8'h41, 1'b0);
      add_byte(8'h20, 1'b0);
      add_byte(8'h1F, 1'b0);
      add_byte(8'hF8, 1'b0);
      add_byte(8'h81, 1'b0);
      add_byte(8'h8C, 1'b0);
      add_byte(8'h61, 1'b0);
      add_byte(8'h62, 1'b0);
      add_byte(8'h02, 1'b0);
      add_byte(8'h30, 1'b0);
      add_byte(8'h0F, 1'b0);
      add_byte(8'h31, 1'b1);
      add_byte(8'h10, 1'b1);
      add_byte(8'hFF, 1'b0);
      add_byte(8'hDB, 1'b0);
      add_byte(8'h4E, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'hAA, 1'b1);
      wait_idle();

      p = 0;
      while (random_bytes < RANDOM_BYTES) begin
         case (p)
            0: set_config(0, 65535, 1'b1, 1'b1);
            1: set_config(8191, 2, 1'b1, 1'b0);
            2: set_config(4096, 0, 1'b1, 1'b1);
            3: set_config(1, 25, 1'b0, 1'b1);
            default: begin
               r = $urandom_range(0, 9);
               cols = (r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 5000 :
                      (r == 3) ? 4096 : $urandom_range(2, 100);
               r = $urandom_range(0, 9);
               nrows = (r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 2 :
                       (r < 6) ? 25 : (r < 9) ? 65535 : $urandom_range(1, 300);
               set_config(cols, nrows, $urandom_range(0, 9) < 7, $urandom_range(0, 1));
            end
         endcase
         steady_run = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(1, 3))
            add_stream(cfg_compressed,
                       cfg_compressed ? $urandom_range(1, 6) : $urandom_range(2, 16));
         wait_idle();
         p++;
      end

      if (mismatches == 0 && expected_cells.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> xbin_cell_stream_decoder_top.f
rtl/xcsd_pkg.sv
rtl/xcsd_csr.sv
rtl/xcsd_ctrl.sv
rtl/xcsd_dpath.sv
rtl/xbin_cell_stream_decoder_top.sv
tb/tb_top.sv
